// ----- hw/rtl/ptpd_pkg.sv -----
// ptpd_pkg: shared widths, constants, codes and command/status types
// for the pan/tilt pd tracker; no dependencies
package ptpd_pkg;

	localparam int ERROR_BITS      = 12;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int GAIN_FRAC_BITS  = 24;
	localparam int GAIN_BITS       = 16;
	localparam int AGE_BITS        = 16;
	localparam int DEG_BITS        = 8;
	localparam int PULSE_BITS      = 12;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 16;

	localparam int ANGLE_BITS   = DEG_BITS + ANGLE_FRAC_BITS;
	localparam int SCALE_SHIFT  = GAIN_FRAC_BITS - ANGLE_FRAC_BITS;
	localparam int DIFF_BITS    = ERROR_BITS + 1;
	localparam int TERM_BITS    = GAIN_BITS + 1 + DIFF_BITS + 1;
	localparam int SUM_BITS     = ((TERM_BITS > ANGLE_BITS + 1) ? TERM_BITS : ANGLE_BITS + 1) + 1;

	localparam int SERVO_K_BITS = 14;
	localparam int SERVO_K      = 11111;
	localparam int T_BITS       = DEG_BITS + SERVO_K_BITS;
	localparam int RECIP_SHIFT  = 32;
	localparam longint RECIP    = ((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000;
	localparam int RECIP_BITS   = 24;
	localparam int PULSE_BASE   = 500;

	localparam int MUL_A_BITS = ((ANGLE_BITS > T_BITS) ? ANGLE_BITS : T_BITS) + 1;
	localparam int MUL_B_BITS = ((RECIP_BITS > GAIN_BITS + 1) ? RECIP_BITS : GAIN_BITS + 1);
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

	localparam logic [GAIN_BITS-1:0] RST_GAIN_P_PAN  = 16'd13422;
	localparam logic [GAIN_BITS-1:0] RST_GAIN_D_PAN  = 16'd3355;
	localparam logic [GAIN_BITS-1:0] RST_GAIN_P_TILT = 16'd10066;
	localparam logic [GAIN_BITS-1:0] RST_GAIN_D_TILT = 16'd3355;
	localparam logic [AGE_BITS-1:0]  RST_TIMEOUT     = 16'd300;
	localparam logic [DEG_BITS-1:0]  RST_FLOOR       = 8'd5;
	localparam logic [DEG_BITS-1:0]  RST_CEILING     = 8'd175;
	localparam logic [DEG_BITS-1:0]  RST_ANGLE_DEG   = 8'd90;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_GAIN_P_PAN,
		CFG_GAIN_D_PAN,
		CFG_GAIN_P_TILT,
		CFG_GAIN_D_TILT,
		CFG_LINK_TIMEOUT,
		CFG_ANGLE_FLOOR,
		CFG_ANGLE_CEILING
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_MUL_P,
		OP_MUL_D,
		OP_SUM,
		OP_UPDATE,
		OP_SCALE,
		OP_RECIP,
		OP_LOAD
	} dp_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_SUM,
		ST_UPDATE,
		ST_SCALE,
		ST_RECIP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic   capture;
		logic   track;
		logic   enabled;
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic track_ok;
		logic stop_req;
	} sts_t;

endpackage

// ----- hw/rtl/pan_tilt_pd_tracker.sv -----
// pan_tilt_pd_tracker: top level of the two-axis pd servo tracker
// depends on ptpd_pkg, ptpd_ctrl, ptpd_datapath (and ptpd_axis below it)
//
// One request is one control tick; it yields exactly one result with both
// servo pulses and the status flags. After the accept a request runs seven
// working steps, or only the scale, reciprocal and output steps once the
// emergency halt is latched, since the pd term and the angle update are
// skipped. The steps are set by the one multiplier per axis, used in turn
// for the proportional and derivative terms, the pulse scale and the
// divide-by-1000 reciprocal. A finished result sits in an output
// register, so a new request is taken while it waits; a further one is
// held only if that register is still full when the next result is ready.
// Configuration writes take effect at once and belong in idle periods.
module pan_tilt_pd_tracker (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [ptpd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [ptpd_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [ptpd_pkg::ERROR_BITS-1:0]  pan_pixel_error,
	input  logic signed [ptpd_pkg::ERROR_BITS-1:0]  tilt_pixel_error,
	input  logic                                    target_seen,
	input  logic [ptpd_pkg::AGE_BITS-1:0]           link_age_ms,
	input  logic                                    stop_press,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [ptpd_pkg::PULSE_BITS-1:0]         pan_pulse_us,
	output logic [ptpd_pkg::PULSE_BITS-1:0]         tilt_pulse_us,
	output logic                                    tracking_active,
	output logic                                    drive_enabled
);

	ptpd_pkg::cmd_t cmd;
	ptpd_pkg::sts_t sts;

	ptpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptpd_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.pan_pixel_error  (pan_pixel_error),
		.tilt_pixel_error (tilt_pixel_error),
		.target_seen      (target_seen),
		.link_age_ms      (link_age_ms),
		.stop_press       (stop_press),
		.cmd              (cmd),
		.sts              (sts),
		.pan_pulse_us     (pan_pulse_us),
		.tilt_pulse_us    (tilt_pulse_us),
		.tracking_active  (tracking_active),
		.drive_enabled    (drive_enabled)
	);

endmodule

// ----- hw/rtl/ptpd_axis.sv -----
// ptpd_axis: one axis of the tracker datapath: pd term, angle update with
// clamp, and angle-to-pulse conversion on a shared multiplier; uses ptpd_pkg
module ptpd_axis (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  ptpd_pkg::cmd_t                          cmd,
	input  logic signed [ptpd_pkg::ERROR_BITS-1:0]  err,
	input  logic [ptpd_pkg::GAIN_BITS-1:0]          gain_p,
	input  logic [ptpd_pkg::GAIN_BITS-1:0]          gain_d,
	input  logic [ptpd_pkg::DEG_BITS-1:0]           angle_floor,
	input  logic [ptpd_pkg::DEG_BITS-1:0]           angle_ceiling,
	output logic [ptpd_pkg::PULSE_BITS-1:0]         pulse_us
);

	logic [ptpd_pkg::ANGLE_BITS-1:0]        angle_q;
	logic signed [ptpd_pkg::ERROR_BITS-1:0] prev_q;
	logic signed [ptpd_pkg::ERROR_BITS-1:0] err_q;
	logic signed [ptpd_pkg::DIFF_BITS-1:0]  diff_q;
	logic signed [ptpd_pkg::TERM_BITS-1:0]  term_q;
	logic signed [ptpd_pkg::PROD_BITS-1:0]  prod_q;
	logic [ptpd_pkg::PULSE_BITS-1:0]        pulse_q;

	logic signed [ptpd_pkg::MUL_A_BITS-1:0] mul_a;
	logic signed [ptpd_pkg::MUL_B_BITS-1:0] mul_b;
	logic signed [ptpd_pkg::PROD_BITS-1:0]  mul_p;
	logic signed [ptpd_pkg::DIFF_BITS-1:0]  diff_now;
	logic signed [ptpd_pkg::TERM_BITS-1:0]  delta;
	logic signed [ptpd_pkg::SUM_BITS-1:0]   a_sum;
	logic signed [ptpd_pkg::SUM_BITS-1:0]   lim_lo;
	logic signed [ptpd_pkg::SUM_BITS-1:0]   lim_hi;
	logic signed [ptpd_pkg::SUM_BITS-1:0]   a_new;
	logic [ptpd_pkg::T_BITS-1:0]            t_val;

	assign diff_now = {err[ptpd_pkg::ERROR_BITS-1], err}
		- {prev_q[ptpd_pkg::ERROR_BITS-1], prev_q};
	assign t_val    = prod_q[ptpd_pkg::ANGLE_FRAC_BITS +: ptpd_pkg::T_BITS];

	always_comb begin
		case (cmd.op)
			ptpd_pkg::OP_MUL_P: begin
				mul_a = {{(ptpd_pkg::MUL_A_BITS-ptpd_pkg::ERROR_BITS){err_q[ptpd_pkg::ERROR_BITS-1]}},
					err_q};
				mul_b = {{(ptpd_pkg::MUL_B_BITS-ptpd_pkg::GAIN_BITS){1'b0}}, gain_p};
			end
			ptpd_pkg::OP_MUL_D: begin
				mul_a = {{(ptpd_pkg::MUL_A_BITS-ptpd_pkg::DIFF_BITS){diff_q[ptpd_pkg::DIFF_BITS-1]}},
					diff_q};
				mul_b = {{(ptpd_pkg::MUL_B_BITS-ptpd_pkg::GAIN_BITS){1'b0}}, gain_d};
			end
			ptpd_pkg::OP_SCALE: begin
				mul_a = {{(ptpd_pkg::MUL_A_BITS-ptpd_pkg::ANGLE_BITS){1'b0}}, angle_q};
				mul_b = ptpd_pkg::MUL_B_BITS'(ptpd_pkg::SERVO_K);
			end
			ptpd_pkg::OP_RECIP: begin
				mul_a = {{(ptpd_pkg::MUL_A_BITS-ptpd_pkg::T_BITS){1'b0}}, t_val};
				mul_b = ptpd_pkg::MUL_B_BITS'(ptpd_pkg::RECIP);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = ptpd_pkg::PROD_BITS'(mul_a) * ptpd_pkg::PROD_BITS'(mul_b);

	// floor conversion from 2^-24 degree to the angle grid
	assign delta  = term_q >>> ptpd_pkg::SCALE_SHIFT;
	assign a_sum  = {{(ptpd_pkg::SUM_BITS-ptpd_pkg::TERM_BITS){delta[ptpd_pkg::TERM_BITS-1]}}, delta}
		+ {{(ptpd_pkg::SUM_BITS-ptpd_pkg::ANGLE_BITS){1'b0}}, angle_q};
	assign lim_lo = {{(ptpd_pkg::SUM_BITS-ptpd_pkg::ANGLE_BITS){1'b0}}, angle_floor,
		{ptpd_pkg::ANGLE_FRAC_BITS{1'b0}}};
	assign lim_hi = {{(ptpd_pkg::SUM_BITS-ptpd_pkg::ANGLE_BITS){1'b0}}, angle_ceiling,
		{ptpd_pkg::ANGLE_FRAC_BITS{1'b0}}};

	// floor before ceiling: an inverted window ends at the ceiling
	always_comb begin
		if (lim_lo > lim_hi) begin
			a_new = lim_hi;
		end else if (a_sum < lim_lo) begin
			a_new = lim_lo;
		end else if (a_sum > lim_hi) begin
			a_new = lim_hi;
		end else begin
			a_new = a_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= {ptpd_pkg::RST_ANGLE_DEG, {ptpd_pkg::ANGLE_FRAC_BITS{1'b0}}};
			prev_q  <= '0;
		end else if (cmd.op == ptpd_pkg::OP_UPDATE) begin
			angle_q <= a_new[ptpd_pkg::ANGLE_BITS-1:0];
			prev_q  <= err_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			err_q  <= cmd.track ? err : '0;
			diff_q <= cmd.track ? diff_now : '0;
		end
		case (cmd.op)
			ptpd_pkg::OP_MUL_P: prod_q <= mul_p;
			ptpd_pkg::OP_MUL_D: begin
				term_q <= prod_q[ptpd_pkg::TERM_BITS-1:0];
				prod_q <= mul_p;
			end
			ptpd_pkg::OP_SUM: term_q <= term_q + prod_q[ptpd_pkg::TERM_BITS-1:0];
			ptpd_pkg::OP_SCALE: prod_q <= mul_p;
			ptpd_pkg::OP_RECIP: prod_q <= mul_p;
			ptpd_pkg::OP_LOAD: pulse_q <= ptpd_pkg::PULSE_BITS'(ptpd_pkg::PULSE_BASE)
				+ prod_q[ptpd_pkg::RECIP_SHIFT +: ptpd_pkg::PULSE_BITS];
			default: ;
		endcase
	end

	assign pulse_us = pulse_q;

endmodule

// ----- hw/rtl/ptpd_datapath.sv -----
// ptpd_datapath: configuration registers, error conditioning, both axis
// datapaths and the result flag registers; uses ptpd_pkg and ptpd_axis
module ptpd_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [ptpd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [ptpd_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic signed [ptpd_pkg::ERROR_BITS-1:0]  pan_pixel_error,
	input  logic signed [ptpd_pkg::ERROR_BITS-1:0]  tilt_pixel_error,
	input  logic                                    target_seen,
	input  logic [ptpd_pkg::AGE_BITS-1:0]           link_age_ms,
	input  logic                                    stop_press,
	input  ptpd_pkg::cmd_t                          cmd,
	output ptpd_pkg::sts_t                          sts,
	output logic [ptpd_pkg::PULSE_BITS-1:0]         pan_pulse_us,
	output logic [ptpd_pkg::PULSE_BITS-1:0]         tilt_pulse_us,
	output logic                                    tracking_active,
	output logic                                    drive_enabled
);

	logic [ptpd_pkg::GAIN_BITS-1:0] gain_p_pan_q;
	logic [ptpd_pkg::GAIN_BITS-1:0] gain_d_pan_q;
	logic [ptpd_pkg::GAIN_BITS-1:0] gain_p_tilt_q;
	logic [ptpd_pkg::GAIN_BITS-1:0] gain_d_tilt_q;
	logic [ptpd_pkg::AGE_BITS-1:0]  timeout_q;
	logic [ptpd_pkg::DEG_BITS-1:0]  floor_q;
	logic [ptpd_pkg::DEG_BITS-1:0]  ceiling_q;
	logic                           track_out_q;
	logic                           enabled_out_q;

	logic signed [ptpd_pkg::ERROR_BITS-1:0] pan_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_pan_q  <= ptpd_pkg::RST_GAIN_P_PAN;
			gain_d_pan_q  <= ptpd_pkg::RST_GAIN_D_PAN;
			gain_p_tilt_q <= ptpd_pkg::RST_GAIN_P_TILT;
			gain_d_tilt_q <= ptpd_pkg::RST_GAIN_D_TILT;
			timeout_q     <= ptpd_pkg::RST_TIMEOUT;
			floor_q       <= ptpd_pkg::RST_FLOOR;
			ceiling_q     <= ptpd_pkg::RST_CEILING;
		end else if (cfg_we) begin
			case (ptpd_pkg::cfg_idx_t'(cfg_index))
				ptpd_pkg::CFG_GAIN_P_PAN:    gain_p_pan_q  <= cfg_data;
				ptpd_pkg::CFG_GAIN_D_PAN:    gain_d_pan_q  <= cfg_data;
				ptpd_pkg::CFG_GAIN_P_TILT:   gain_p_tilt_q <= cfg_data;
				ptpd_pkg::CFG_GAIN_D_TILT:   gain_d_tilt_q <= cfg_data;
				ptpd_pkg::CFG_LINK_TIMEOUT:  timeout_q     <= cfg_data;
				ptpd_pkg::CFG_ANGLE_FLOOR:   floor_q       <= cfg_data[ptpd_pkg::DEG_BITS-1:0];
				ptpd_pkg::CFG_ANGLE_CEILING: ceiling_q     <= cfg_data[ptpd_pkg::DEG_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign sts.track_ok = (link_age_ms <= timeout_q) && target_seen;
	assign sts.stop_req = stop_press;

	// pan is negated, most negative value saturates
	assign pan_err = (pan_pixel_error == {1'b1, {(ptpd_pkg::ERROR_BITS-1){1'b0}}})
		? {1'b0, {(ptpd_pkg::ERROR_BITS-1){1'b1}}} : -pan_pixel_error;

	ptpd_axis u_pan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.err           (pan_err),
		.gain_p        (gain_p_pan_q),
		.gain_d        (gain_d_pan_q),
		.angle_floor   (floor_q),
		.angle_ceiling (ceiling_q),
		.pulse_us      (pan_pulse_us)
	);

	ptpd_axis u_tilt (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.err           (tilt_pixel_error),
		.gain_p        (gain_p_tilt_q),
		.gain_d        (gain_d_tilt_q),
		.angle_floor   (floor_q),
		.angle_ceiling (ceiling_q),
		.pulse_us      (tilt_pulse_us)
	);

	always_ff @(posedge clk) begin
		if (cmd.op == ptpd_pkg::OP_LOAD) begin
			track_out_q   <= cmd.track;
			enabled_out_q <= cmd.enabled;
		end
	end

	assign tracking_active = track_out_q;
	assign drive_enabled   = enabled_out_q;

endmodule

// ----- hw/rtl/ptpd_ctrl.sv -----
// ptpd_ctrl: request sequencer for the tracker: handshakes, halt latch and
// the step commands for the datapath; uses ptpd_pkg
module ptpd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  ptpd_pkg::sts_t  sts,
	output ptpd_pkg::cmd_t  cmd
);

	ptpd_pkg::state_t state_q;
	ptpd_pkg::state_t state_nxt;
	logic             halt_q;
	logic             track_q;
	logic             out_valid_q;

	logic accept;
	logic halt_now;
	logic track_now;
	logic out_free;

	assign accept    = in_valid && (state_q == ptpd_pkg::ST_IDLE);
	assign halt_now  = halt_q || sts.stop_req;
	assign track_now = !halt_now && sts.track_ok;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		case (state_q)
			ptpd_pkg::ST_IDLE: begin
				if (!in_valid) begin
					state_nxt = ptpd_pkg::ST_IDLE;
				end else if (halt_now) begin
					state_nxt = ptpd_pkg::ST_SCALE;
				end else begin
					state_nxt = ptpd_pkg::ST_MUL_P;
				end
			end
			ptpd_pkg::ST_MUL_P:  state_nxt = ptpd_pkg::ST_MUL_D;
			ptpd_pkg::ST_MUL_D:  state_nxt = ptpd_pkg::ST_SUM;
			ptpd_pkg::ST_SUM:    state_nxt = ptpd_pkg::ST_UPDATE;
			ptpd_pkg::ST_UPDATE: state_nxt = ptpd_pkg::ST_SCALE;
			ptpd_pkg::ST_SCALE:  state_nxt = ptpd_pkg::ST_RECIP;
			ptpd_pkg::ST_RECIP:  state_nxt = ptpd_pkg::ST_OUT;
			ptpd_pkg::ST_OUT:    state_nxt = out_free ? ptpd_pkg::ST_IDLE : ptpd_pkg::ST_OUT;
			default:             state_nxt = ptpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.capture = accept;
		cmd.track   = (state_q == ptpd_pkg::ST_IDLE) ? track_now : track_q;
		cmd.enabled = !halt_q;
		case (state_q)
			ptpd_pkg::ST_MUL_P:  cmd.op = ptpd_pkg::OP_MUL_P;
			ptpd_pkg::ST_MUL_D:  cmd.op = ptpd_pkg::OP_MUL_D;
			ptpd_pkg::ST_SUM:    cmd.op = ptpd_pkg::OP_SUM;
			ptpd_pkg::ST_UPDATE: cmd.op = ptpd_pkg::OP_UPDATE;
			ptpd_pkg::ST_SCALE:  cmd.op = ptpd_pkg::OP_SCALE;
			ptpd_pkg::ST_RECIP:  cmd.op = ptpd_pkg::OP_RECIP;
			ptpd_pkg::ST_OUT:    cmd.op = out_free ? ptpd_pkg::OP_LOAD : ptpd_pkg::OP_NONE;
			default:             cmd.op = ptpd_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptpd_pkg::ST_IDLE;
			halt_q      <= 1'b0;
			track_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				halt_q  <= halt_now;
				track_q <= track_now;
			end
			if (cmd.op == ptpd_pkg::OP_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ptpd_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- tb/pan_tilt_pd_tracker_tb.sv -----
// pan_tilt_pd_tracker_tb: self-checking bench for the two-axis pd servo tracker
// directed table, random control ticks over several register settings, then halt rows and random stop presses
// depends on ptpd_pkg and pan_tilt_pd_tracker
`timescale 1ns / 100ps

module pan_tilt_pd_tracker_tb;
	import ptpd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_TICKS = 160;
	localparam int HALT_TICKS = 20;
	localparam int ERR_MAX = (1 << (ERROR_BITS - 1)) - 1;
	localparam int ERR_MIN = -(1 << (ERROR_BITS - 1));
	localparam longint PULSE_NUM = 11111;
	localparam longint PULSE_DEN = 1000;

	typedef struct packed {
		logic [ERROR_BITS-1:0] pan_err;
		logic [ERROR_BITS-1:0] tilt_err;
		logic                  seen;
		logic [AGE_BITS-1:0]   age;
		logic                  stop;
	} tick_t;

	typedef struct packed {
		logic [PULSE_BITS-1:0] pan_us;
		logic [PULSE_BITS-1:0] tilt_us;
		logic                  track;
		logic                  enabled;
	} servo_out_t;

	typedef struct packed {
		tick_t      t;
		logic       typed;
		servo_out_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [ERROR_BITS-1:0] pan_pixel_error = '0;
	logic signed [ERROR_BITS-1:0] tilt_pixel_error = '0;
	logic target_seen = 1'b0;
	logic [AGE_BITS-1:0] link_age_ms = '0;
	logic stop_press = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PULSE_BITS-1:0] pan_pulse_us;
	logic [PULSE_BITS-1:0] tilt_pulse_us;
	logic tracking_active;
	logic drive_enabled;

	pan_tilt_pd_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pan_pixel_error(pan_pixel_error),
		.tilt_pixel_error(tilt_pixel_error),
		.target_seen(target_seen),
		.link_age_ms(link_age_ms),
		.stop_press(stop_press),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pan_pulse_us(pan_pulse_us),
		.tilt_pulse_us(tilt_pulse_us),
		.tracking_active(tracking_active),
		.drive_enabled(drive_enabled)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [CFG_DATA_BITS-1:0] cfg_shadow [0:6];
	longint pan_ang = longint'(RST_ANGLE_DEG) << ANGLE_FRAC_BITS;
	longint tilt_ang = longint'(RST_ANGLE_DEG) << ANGLE_FRAC_BITS;
	longint pan_prev = 0;
	longint tilt_prev = 0;
	bit halted = 1'b0;

	servo_out_t expected_servo [$];
	row_t directed_rows [$];
	int mismatches = 0;
	int burst_left = 0;
	int pan_bias = 0;
	int tilt_bias = 0;
	int rx_tick = 0;
	int rx_mode = 0;

	function automatic longint step_axis(input longint ang, input longint e, input longint prev,
			input longint kp, input longint kd);
		longint c, a, lo, hi;
		c = kp * e + kd * (e - prev);
		a = ang + (c >>> SCALE_SHIFT);
		lo = longint'(cfg_shadow[CFG_ANGLE_FLOOR]) << ANGLE_FRAC_BITS;
		hi = longint'(cfg_shadow[CFG_ANGLE_CEILING]) << ANGLE_FRAC_BITS;
		if (a < lo)
			a = lo;
		if (a > hi)
			a = hi;
		return a;
	endfunction

	function automatic logic [PULSE_BITS-1:0] angle_to_pulse(input longint ang);
		longint p;
		p = PULSE_BASE + (ang * PULSE_NUM) / (PULSE_DEN << ANGLE_FRAC_BITS);
		return p[PULSE_BITS-1:0];
	endfunction

	function automatic servo_out_t predict_servo(input tick_t t);
		servo_out_t r;
		longint ex, ey;
		bit trk;
		trk = 1'b0;
		if (t.stop)
			halted = 1'b1;
		if (!halted) begin
			ex = longint'($signed(t.pan_err));
			ey = longint'($signed(t.tilt_err));
			trk = (t.age <= cfg_shadow[CFG_LINK_TIMEOUT]) && t.seen;
			if (trk) begin
				ex = -ex;
				if (ex > ERR_MAX)
					ex = ERR_MAX;
			end else begin
				ex = 0;
				ey = 0;
				pan_prev = 0;
				tilt_prev = 0;
			end
			pan_ang = step_axis(pan_ang, ex, pan_prev,
				longint'(cfg_shadow[CFG_GAIN_P_PAN]), longint'(cfg_shadow[CFG_GAIN_D_PAN]));
			pan_prev = ex;
			tilt_ang = step_axis(tilt_ang, ey, tilt_prev,
				longint'(cfg_shadow[CFG_GAIN_P_TILT]), longint'(cfg_shadow[CFG_GAIN_D_TILT]));
			tilt_prev = ey;
		end
		r.pan_us = angle_to_pulse(pan_ang);
		r.tilt_us = angle_to_pulse(tilt_ang);
		r.track = trk;
		r.enabled = !halted;
		return r;
	endfunction

	function automatic logic [ERROR_BITS-1:0] pick_error(input int bias);
		int v, pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			v = bias + int'($urandom_range(0, 128)) - 64;
		else if (pick < 90)
			v = int'($urandom_range(0, 4095)) - 2048;
		else if (pick < 94)
			v = ERR_MIN;
		else if (pick < 98)
			v = ERR_MAX;
		else
			v = 0;
		if (v > ERR_MAX)
			v = ERR_MAX;
		if (v < ERR_MIN)
			v = ERR_MIN;
		return v[ERROR_BITS-1:0];
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		logic [AGE_BITS-1:0] tmo;
		int pick;
		tmo = cfg_shadow[CFG_LINK_TIMEOUT];
		t.stop = 1'b0;
		t.seen = ($urandom_range(0, 99) < 85);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			t.age = AGE_BITS'($urandom_range(0, tmo));
		else if (pick < 78)
			t.age = tmo;
		else if (pick < 84)
			t.age = tmo + 1'b1;
		else if (pick < 95)
			t.age = AGE_BITS'($urandom);
		else
			t.age = '1;
		t.pan_err = pick_error(pan_bias);
		t.tilt_err = pick_error(tilt_bias);
		return t;
	endfunction

	task automatic add_row(input int pe, input int te, input logic seen, input int age,
			input logic stop, input logic typed, input int want_pan, input int want_tilt,
			input logic want_trk, input logic want_en);
		row_t r;
		r.t.pan_err = pe[ERROR_BITS-1:0];
		r.t.tilt_err = te[ERROR_BITS-1:0];
		r.t.seen = seen;
		r.t.age = age[AGE_BITS-1:0];
		r.t.stop = stop;
		r.typed = typed;
		r.want.pan_us = want_pan[PULSE_BITS-1:0];
		r.want.tilt_us = want_tilt[PULSE_BITS-1:0];
		r.want.track = want_trk;
		r.want.enabled = want_en;
		directed_rows.push_back(r);
	endtask

	task automatic send_tick(input tick_t t, input logic typed, input servo_out_t want);
		servo_out_t pred;
		@(negedge clk);
		in_valid <= 1'b1;
		pan_pixel_error <= t.pan_err;
		tilt_pixel_error <= t.tilt_err;
		target_seen <= t.seen;
		link_age_ms <= t.age;
		stop_press <= t.stop;
		do
			@(posedge clk);
		while (!in_ready);
		pred = predict_servo(t);
		expected_servo.push_back(typed ? want : pred);
	endtask

	// bursts of requests separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(0, 40);
			pan_bias = int'($urandom_range(0, 3000)) - 1500;
			tilt_bias = int'($urandom_range(0, 3000)) - 1500;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_servo.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		if (idx == CFG_ANGLE_FLOOR || idx == CFG_ANGLE_CEILING)
			cfg_shadow[idx] = CFG_DATA_BITS'(v[DEG_BITS-1:0]);
		else
			cfg_shadow[idx] = v;
	endtask

	task automatic report(input string what, input servo_out_t want, input servo_out_t got);
		if (mismatches < 10)
			$display("%0t %s: expected pan %0d tilt %0d trk %0b en %0b, got pan %0d tilt %0d trk %0b en %0b",
				$time, what, want.pan_us, want.tilt_us, want.track, want.enabled,
				got.pan_us, got.tilt_us, got.track, got.enabled);
		mismatches++;
	endtask

	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 50 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (rx_tick % 5 == 0);
			default: out_ready <= (rx_tick % 50 >= 40);
		endcase
	end

	always @(posedge clk) begin : check_results
		servo_out_t want, got;
		if (arst_n && out_valid && out_ready) begin
			got.pan_us = pan_pulse_us;
			got.tilt_us = tilt_pulse_us;
			got.track = tracking_active;
			got.enabled = drive_enabled;
			if (expected_servo.size() == 0) begin
				report("unexpected result", got, got);
			end else begin
				want = expected_servo.pop_front();
				if (got.pan_us !== want.pan_us || got.tilt_us !== want.tilt_us ||
						got.track !== want.track || got.enabled !== want.enabled)
					report("mismatch", want, got);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL pan_tilt_pd_tracker");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_DATA_BITS-1:0] vals [0:6];
		servo_out_t none;
		int halt_from, ph, i;
		none = '0;
		cfg_shadow[CFG_GAIN_P_PAN] = RST_GAIN_P_PAN;
		cfg_shadow[CFG_GAIN_D_PAN] = RST_GAIN_D_PAN;
		cfg_shadow[CFG_GAIN_P_TILT] = RST_GAIN_P_TILT;
		cfg_shadow[CFG_GAIN_D_TILT] = RST_GAIN_D_TILT;
		cfg_shadow[CFG_LINK_TIMEOUT] = RST_TIMEOUT;
		cfg_shadow[CFG_ANGLE_FLOOR] = RST_FLOOR;
		cfg_shadow[CFG_ANGLE_CEILING] = RST_CEILING;

		// tracking off or zero error holds both axes at 90 degrees
		add_row(0, 0, 0, 0, 0, 1, 1499, 1499, 0, 1);
		add_row(-2048, 2047, 0, 0, 0, 1, 1499, 1499, 0, 1);
		add_row(2047, -2048, 1, 301, 0, 1, 1499, 1499, 0, 1);
		add_row(-2048, -2048, 1, 65535, 0, 1, 1499, 1499, 0, 1);
		add_row(0, 0, 1, 300, 0, 1, 1499, 1499, 1, 1);
		add_row(0, 0, 1, 0, 0, 1, 1499, 1499, 1, 1);
		// most negative pan error saturates when negated, among other rows checked against the predictor
		add_row(-2048, 2047, 1, 300, 0, 0, 0, 0, 0, 0);
		add_row(2047, -2048, 1, 0, 0, 0, 0, 0, 0, 0);
		add_row(-2048, -2048, 1, 100, 0, 0, 0, 0, 0, 0);
		add_row(2047, 2047, 1, 299, 0, 0, 0, 0, 0, 0);
		add_row(1, -1, 1, 5, 0, 0, 0, 0, 0, 0);
		add_row(-1, 1, 1, 5, 0, 0, 0, 0, 0, 0);
		add_row(1365, -1366, 1, 16'h5555, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 300, 0, 0, 0, 0, 0, 0);
		add_row(100, -100, 1, 0, 0, 0, 0, 0, 0, 0);
		add_row(100, -100, 1, 0, 0, 0, 0, 0, 0, 0);
		halt_from = directed_rows.size();
		// stop press latches the halt; later requests leave the angles unchanged and report the drive disabled
		add_row(50, 50, 1, 0, 1, 0, 0, 0, 0, 0);
		add_row(-2048, 2047, 1, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		add_row(2047, -2048, 1, 65535, 0, 0, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < halt_from; i++) begin
			send_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].want);
			pace();
		end

		for (ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: begin
					for (i = 0; i < 5; i++)
						vals[i] = '1;
					vals[5] = {8'($urandom), 8'd0};
					vals[6] = {8'($urandom), 8'd255};
				end
				1: begin
					for (i = 0; i < 5; i++)
						vals[i] = '0;
					vals[5] = 16'd180;
					vals[6] = 16'd180;
				end
				2: begin
					for (i = 0; i < 5; i++)
						vals[i] = CFG_DATA_BITS'($urandom);
					vals[5] = 16'd120;
					vals[6] = 16'd60;
				end
				3: begin
					for (i = 0; i < 4; i++)
						vals[i] = CFG_DATA_BITS'($urandom);
					vals[4] = CFG_DATA_BITS'($urandom_range(0, 1000));
					vals[5] = CFG_DATA_BITS'($urandom_range(0, 40));
					vals[6] = CFG_DATA_BITS'($urandom_range(140, 180));
				end
				4: begin
					for (i = 0; i < 7; i++)
						vals[i] = CFG_DATA_BITS'($urandom);
				end
				default: begin
					vals[0] = RST_GAIN_P_PAN;
					vals[1] = RST_GAIN_D_PAN;
					vals[2] = RST_GAIN_P_TILT;
					vals[3] = RST_GAIN_D_TILT;
					vals[4] = RST_TIMEOUT;
					vals[5] = RST_FLOOR;
					vals[6] = RST_CEILING;
				end
			endcase
			for (i = 0; i < 7; i++)
				write_reg(cfg_idx_t'(i), vals[i]);
			@(negedge clk);
			cfg_we <= 1'b0;
			for (i = 0; i < PHASE_TICKS; i++) begin
				send_tick(random_tick(), 1'b0, none);
				pace();
			end
		end

		settle();
		for (i = halt_from; i < directed_rows.size(); i++) begin
			send_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].want);
			pace();
		end
		for (i = 0; i < HALT_TICKS; i++) begin
			tick_t t;
			t = random_tick();
			t.stop = 1'($urandom_range(0, 1));
			send_tick(t, 1'b0, none);
			pace();
		end

		settle();
		if (mismatches == 0)
			$display("PASS pan_tilt_pd_tracker");
		else
			$display("FAIL pan_tilt_pd_tracker");
		$finish;
	end

endmodule
